// ----- src/hnq_pkg.sv -----
// ----------------------------------------------------------------------------
// hnq_pkg
// Shared types, constants and helpers for the heightmap normal query unit.
// ----------------------------------------------------------------------------
package hnq_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int MIN_SIDE   = 4;
  localparam int COORD_W    = $clog2(MAX_SIDE);
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int MEM_DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int SIZE_W     = 9;
  localparam int POS_W      = 16;
  localparam int HGT_W      = 8;
  localparam int NRM_W      = 16;
  localparam int ACC_W      = 12;   // signed window sums
  localparam int SQ_W       = 21;   // squares and |S|^2
  localparam int QUO_W      = 31;   // mag^2 * 2^30 / q
  localparam int ROOT_W     = 32;
  localparam int LO_W       = 15;   // unit component magnitude, up to 2^14
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int WIN_N      = 8;    // window samples that enter the sums
  localparam int WIN_W      = $clog2(WIN_N);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIDE);
  localparam logic [SQ_W-1:0]   SZ_SQ      = SQ_W'(576);   // (6 faces * 4)^2
  localparam logic [4:0]        DIV_STEPS  = 5'd29;
  localparam logic [4:0]        ROOT_STEPS = 5'd15;

  typedef enum logic {CMD_WRITE = 1'b0, CMD_QUERY = 1'b1} cmd_t;

  typedef struct packed {
    logic                is_query;
    logic                interior;
    logic [ADDR_W-1:0]   addr;
    logic [SIZE_W-1:0]   stride;
    logic [HGT_W-1:0]    sample;
  } fifo_entry_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_DRAIN, BK_SQUARE, BK_SUM, BK_NSTART, BK_NWAIT, BK_OUT
  } back_state_t;

  typedef enum logic [1:0] {NRM_IDLE, NRM_DIV, NRM_ROOT} norm_state_t;

  // Window order: (0,0) (1,0) (2,0) (0,1) (2,1) (0,2) (1,2) (2,2) as (dx,dy).
  function automatic logic [1:0] win_dx(input logic [WIN_W-1:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0, 3'd3, 3'd5: r = 2'd0;
      3'd1, 3'd6:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] win_dy(input logic [WIN_W-1:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // sx = h00 + h01 + h02 - h20 - h21 - h22
  function automatic logic signed [2:0] coef_x(input logic [WIN_W-1:0] k);
    logic signed [2:0] r;
    unique case (k)
      3'd0, 3'd3, 3'd5: r = 3'sd1;
      3'd2, 3'd4, 3'd7: r = -3'sd1;
      default:          r = 3'sd0;
    endcase
    return r;
  endfunction

  // sy = h00 - h01 + 2*h10 - 2*h12 + h21 - h22
  function automatic logic signed [2:0] coef_y(input logic [WIN_W-1:0] k);
    logic signed [2:0] r;
    unique case (k)
      3'd0, 3'd4: r = 3'sd1;
      3'd3, 3'd7: r = -3'sd1;
      3'd1:       r = 3'sd2;
      3'd6:       r = -3'sd2;
      default:    r = 3'sd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/heightmap_normal_query_unit.sv -----
// ----------------------------------------------------------------------------
// heightmap_normal_query_unit
// Square 8-bit heightmap with height and vertex-normal queries.
// ----------------------------------------------------------------------------
// Input stream: tuser = cmd (0 write sample, 1 query), tdata = pos_x, pos_y,
// sample. Writes outside the map are dropped; queries clamp into the map.
// Output stream: one transfer per query with the height in quarter units and
// the Q1.14 unit normal (zero on row and column 0 and on the last two of each).
// APB register 0 (byte address 0): map_size, saturated to 4..256 when used.
// Change it only while the unit is idle.
// Items pass a 4-entry queue into the execution side, which does one item at
// a time. A write is stored as it leaves the queue. An interior query takes
// 8 reads from the single-port height store, squaring and summing, then a
// 30-step divide and a 16-step square root in three component units running
// side by side.
// The result sits in an output register; while it is not taken the execution
// side keeps draining writes, and input stalls only when the queue fills.
// Reset clears the queue, control and map_size; the height store is not
// cleared, and a query must only touch samples that were written.
// ----------------------------------------------------------------------------
module heightmap_normal_query_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // pos_x[15:0], pos_y[31:16], sample[39:32]
  input  logic        in_tuser,    // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // height_quarters[7:0], normal_x[23:8],
                                   // normal_y[39:24], normal_z[55:40]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [hnq_pkg::SIZE_W-1:0] map_size_r;
  logic                       push, pop;
  hnq_pkg::fifo_entry_t       push_data, head;
  hnq_pkg::fifo_stat_t        fifo_stat;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_size_r <= hnq_pkg::SIZE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      map_size_r <= cfg_pwdata[hnq_pkg::SIZE_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(map_size_r);

  hnq_front u_front (
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .map_size(map_size_r), .fifo_stat, .push, .push_data
  );

  hnq_fifo u_fifo (
    .clk, .rst_n, .push, .push_data, .pop, .head, .stat(fifo_stat)
  );

  hnq_back u_back (
    .clk, .rst_n, .head, .fifo_stat, .pop, .out_tvalid, .out_tready, .out_tdata
  );

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.count <= hnq_pkg::FIFO_CNT_W'(hnq_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

  a_nz_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[55])
    else $error("normal_z negative");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[55:40] == 16'd0) |-> (out_tdata[39:8] == 32'd0))
    else $error("partial zero normal");
`endif

endmodule

// ----- src/hnq_front.sv -----
// ----------------------------------------------------------------------------
// hnq_front
// Input side: checks writes against the map, clamps queries, forms addresses.
// ----------------------------------------------------------------------------
module hnq_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [39:0]                 in_tdata,   // pos_x, pos_y, sample
  input  logic                        in_tuser,   // cmd
  input  logic [hnq_pkg::SIZE_W-1:0]  map_size,
  input  hnq_pkg::fifo_stat_t         fifo_stat,
  output logic                        push,
  output hnq_pkg::fifo_entry_t        push_data
);

  logic [hnq_pkg::POS_W-1:0]    px, py;
  logic [hnq_pkg::SIZE_W-1:0]   side, side_m1;
  logic [hnq_pkg::COORD_W-1:0]  cx, cy;
  logic                         in_map, is_query, interior;
  logic [hnq_pkg::COORD_W+hnq_pkg::SIZE_W-1:0] row_off;

  assign px       = in_tdata[15:0];
  assign py       = in_tdata[31:16];
  assign is_query = (in_tuser == hnq_pkg::CMD_QUERY);

  always_comb begin
    if (map_size < hnq_pkg::SIZE_W'(hnq_pkg::MIN_SIDE)) begin
      side = hnq_pkg::SIZE_W'(hnq_pkg::MIN_SIDE);
    end else if (map_size > hnq_pkg::SIZE_W'(hnq_pkg::MAX_SIDE)) begin
      side = hnq_pkg::SIZE_W'(hnq_pkg::MAX_SIDE);
    end else begin
      side = map_size;
    end
  end

  assign side_m1 = side - 1'b1;
  assign in_map  = !px[15] && !py[15] &&
                   (px < hnq_pkg::POS_W'(side)) && (py < hnq_pkg::POS_W'(side));

  always_comb begin
    if (!is_query) begin
      cx = px[hnq_pkg::COORD_W-1:0];
    end else if (px[15]) begin
      cx = '0;
    end else if (px > hnq_pkg::POS_W'(side_m1)) begin
      cx = side_m1[hnq_pkg::COORD_W-1:0];
    end else begin
      cx = px[hnq_pkg::COORD_W-1:0];
    end
    if (!is_query) begin
      cy = py[hnq_pkg::COORD_W-1:0];
    end else if (py[15]) begin
      cy = '0;
    end else if (py > hnq_pkg::POS_W'(side_m1)) begin
      cy = side_m1[hnq_pkg::COORD_W-1:0];
    end else begin
      cy = py[hnq_pkg::COORD_W-1:0];
    end
  end

  assign interior = (cx != '0) && (cy != '0) &&
                    (hnq_pkg::SIZE_W'(cx) + 2'd2 < side) &&
                    (hnq_pkg::SIZE_W'(cy) + 2'd2 < side);

  assign row_off = cy * side;

  assign in_tready          = !fifo_stat.full;
  assign push               = in_tvalid && in_tready && (is_query || in_map);
  assign push_data.is_query = is_query;
  assign push_data.interior = interior;
  assign push_data.addr     = hnq_pkg::ADDR_W'(row_off) + hnq_pkg::ADDR_W'(cx);
  assign push_data.stride   = side;
  assign push_data.sample   = in_tdata[39:32];

endmodule

// ----- src/hnq_fifo.sv -----
// ----------------------------------------------------------------------------
// hnq_fifo
// Short command queue between the front and back sides.
// ----------------------------------------------------------------------------
module hnq_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  hnq_pkg::fifo_entry_t  push_data,
  input  logic                  pop,
  output hnq_pkg::fifo_entry_t  head,
  output hnq_pkg::fifo_stat_t   stat
);

  hnq_pkg::fifo_entry_t              entry_r [hnq_pkg::FIFO_DEPTH];
  logic [hnq_pkg::FIFO_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [hnq_pkg::FIFO_CNT_W-1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = entry_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == hnq_pkg::FIFO_CNT_W'(hnq_pkg::FIFO_DEPTH));

endmodule

// ----- src/hnq_norm.sv -----
// ----------------------------------------------------------------------------
// hnq_norm
// One normal component: round(16384*|s|/sqrt(q)) from s^2 and q, by a
// bit-serial divide (mag^2 * 2^30 / q) followed by a bit-serial square root.
// ----------------------------------------------------------------------------
module hnq_norm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hnq_pkg::SQ_W-1:0]    mag_sq,
  input  logic [hnq_pkg::SQ_W-1:0]    q,
  output logic                        busy,
  output logic [hnq_pkg::LO_W-1:0]    lo
);

  hnq_pkg::norm_state_t            state_r, state_nxt;
  logic [4:0]                      cnt_r;
  logic [hnq_pkg::SQ_W-1:0]        rem_r, q_r;
  logic [hnq_pkg::QUO_W-1:0]       acc_r;
  logic [hnq_pkg::ROOT_W-1:0]      res_r, bit_r, trial;
  logic [hnq_pkg::SQ_W:0]          rem2;
  logic                            ge0, ge;
  logic [16:0]                     rounded;

  assign ge0   = (mag_sq >= q);
  assign rem2  = {rem_r, 1'b0};
  assign ge    = (rem2 >= {1'b0, q_r});
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hnq_pkg::NRM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hnq_pkg::NRM_IDLE: if (start) state_nxt = hnq_pkg::NRM_DIV;
      hnq_pkg::NRM_DIV:  if (cnt_r == '0) state_nxt = hnq_pkg::NRM_ROOT;
      hnq_pkg::NRM_ROOT: if (cnt_r == '0) state_nxt = hnq_pkg::NRM_IDLE;
      default:           state_nxt = hnq_pkg::NRM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      hnq_pkg::NRM_IDLE: begin
        if (start) begin
          // mag^2 <= q, so the top quotient bit is set only when they match
          q_r   <= q;
          rem_r <= ge0 ? mag_sq - q : mag_sq;
          acc_r <= hnq_pkg::QUO_W'(ge0);
          res_r <= '0;
          bit_r <= hnq_pkg::ROOT_W'(1) << 30;
          cnt_r <= hnq_pkg::DIV_STEPS;
        end
      end
      hnq_pkg::NRM_DIV: begin
        rem_r <= ge ? hnq_pkg::SQ_W'(rem2 - {1'b0, q_r}) : rem2[hnq_pkg::SQ_W-1:0];
        acc_r <= {acc_r[hnq_pkg::QUO_W-2:0], ge};
        cnt_r <= (cnt_r == '0) ? hnq_pkg::ROOT_STEPS : cnt_r - 1'b1;
      end
      hnq_pkg::NRM_ROOT: begin
        if ({1'b0, acc_r} >= trial) begin
          acc_r <= hnq_pkg::QUO_W'({1'b0, acc_r} - trial);
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  // largest m with 2m-1 <= isqrt
  assign rounded = {1'b0, res_r[15:0]} + 17'd1;
  assign lo      = rounded[hnq_pkg::LO_W:1];
  assign busy    = (state_r != hnq_pkg::NRM_IDLE);

endmodule

// ----- src/hnq_back.sv -----
// ----------------------------------------------------------------------------
// hnq_back
// Execution side: height store, window gather, sums, normalize, result reg.
// ----------------------------------------------------------------------------
module hnq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hnq_pkg::fifo_entry_t  head,
  input  hnq_pkg::fifo_stat_t   fifo_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [55:0]           out_tdata
);

  logic [hnq_pkg::HGT_W-1:0]  mem [hnq_pkg::MEM_DEPTH];
  logic [hnq_pkg::HGT_W-1:0]  rdata_r;
  logic [hnq_pkg::ADDR_W-1:0] mem_addr, rd_addr, row_step;
  logic                       mem_we, rd_issue, start, out_load;

  hnq_pkg::back_state_t       state_r, state_nxt;
  logic [hnq_pkg::ADDR_W-1:0] base_r;
  logic [hnq_pkg::SIZE_W-1:0] stride_r;
  logic                       interior_r, rd_v_r, out_valid_r;
  logic [hnq_pkg::WIN_W-1:0]  k_r, rd_k_r, last_k;
  logic signed [hnq_pkg::ACC_W-1:0] sx_r, sy_r, tx, ty, samp_ext;
  logic signed [23:0]         sxp, syp;
  logic [hnq_pkg::SQ_W-1:0]   sxsq_r, sysq_r, q_r;
  logic [hnq_pkg::HGT_W-1:0]  h00_r;
  logic [2:0]                 busy;
  logic [hnq_pkg::LO_W-1:0]   lo [3];
  logic [hnq_pkg::NRM_W-1:0]  nx, ny, nz;
  logic [55:0]                out_data_r;

  assign last_k = interior_r ? hnq_pkg::WIN_W'(hnq_pkg::WIN_N - 1) : '0;

  always_comb begin
    unique case (hnq_pkg::win_dy(k_r))
      2'd0:    row_step = '0;
      2'd1:    row_step = hnq_pkg::ADDR_W'(stride_r);
      default: row_step = hnq_pkg::ADDR_W'({stride_r, 1'b0});
    endcase
  end
  assign rd_addr = base_r + row_step + hnq_pkg::ADDR_W'(hnq_pkg::win_dx(k_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hnq_pkg::BK_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= rd_issue;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = rd_addr;
    rd_issue  = 1'b0;
    start     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      hnq_pkg::BK_IDLE: begin
        if (!fifo_stat.empty) begin
          pop = 1'b1;
          if (!head.is_query) begin
            mem_we   = 1'b1;
            mem_addr = head.addr;
          end else begin
            state_nxt = hnq_pkg::BK_READ;
          end
        end
      end
      hnq_pkg::BK_READ: begin
        rd_issue = 1'b1;
        if (k_r == last_k) state_nxt = hnq_pkg::BK_DRAIN;
      end
      hnq_pkg::BK_DRAIN:  state_nxt = interior_r ? hnq_pkg::BK_SQUARE : hnq_pkg::BK_OUT;
      hnq_pkg::BK_SQUARE: state_nxt = hnq_pkg::BK_SUM;
      hnq_pkg::BK_SUM:    state_nxt = hnq_pkg::BK_NSTART;
      hnq_pkg::BK_NSTART: begin
        start     = 1'b1;
        state_nxt = hnq_pkg::BK_NWAIT;
      end
      hnq_pkg::BK_NWAIT:  if (busy == '0) state_nxt = hnq_pkg::BK_OUT;
      hnq_pkg::BK_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = hnq_pkg::BK_IDLE;
        end
      end
      default: state_nxt = hnq_pkg::BK_IDLE;
    endcase
  end

  // single-port height store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= head.sample;
    end
    rdata_r <= mem[mem_addr];
  end

  // sample zero-extended to the sum width so a coefficient of 2 cannot wrap
  assign samp_ext = $signed({{(hnq_pkg::ACC_W - hnq_pkg::HGT_W){1'b0}}, rdata_r});
  assign tx  = hnq_pkg::ACC_W'(hnq_pkg::coef_x(rd_k_r)) * samp_ext;
  assign ty  = hnq_pkg::ACC_W'(hnq_pkg::coef_y(rd_k_r)) * samp_ext;
  assign sxp = sx_r * sx_r;
  assign syp = sy_r * sy_r;

  always_ff @(posedge clk) begin
    if (pop && head.is_query) begin
      base_r     <= head.addr;
      stride_r   <= head.stride;
      interior_r <= head.interior;
      k_r        <= '0;
      sx_r       <= '0;
      sy_r       <= '0;
    end
    if (rd_issue) begin
      k_r    <= k_r + 1'b1;
      rd_k_r <= k_r;
    end
    if (rd_v_r) begin
      sx_r <= sx_r + tx;
      sy_r <= sy_r + ty;
      if (rd_k_r == '0) h00_r <= rdata_r;
    end
    if (state_r == hnq_pkg::BK_SQUARE) begin
      sxsq_r <= sxp[hnq_pkg::SQ_W-1:0];
      sysq_r <= syp[hnq_pkg::SQ_W-1:0];
    end
    if (state_r == hnq_pkg::BK_SUM) begin
      q_r <= sxsq_r + sysq_r + hnq_pkg::SZ_SQ;
    end
    if (out_load) begin
      out_data_r <= {nz, ny, nx, h00_r};
    end
  end

  hnq_norm u_norm_x (.clk, .rst_n, .start, .mag_sq(sxsq_r), .q(q_r),
                     .busy(busy[0]), .lo(lo[0]));
  hnq_norm u_norm_y (.clk, .rst_n, .start, .mag_sq(sysq_r), .q(q_r),
                     .busy(busy[1]), .lo(lo[1]));
  hnq_norm u_norm_z (.clk, .rst_n, .start, .mag_sq(hnq_pkg::SZ_SQ), .q(q_r),
                     .busy(busy[2]), .lo(lo[2]));

  always_comb begin
    if (!interior_r) begin
      nx = '0;
      ny = '0;
      nz = '0;
    end else begin
      nx = sx_r[hnq_pkg::ACC_W-1] ? hnq_pkg::NRM_W'(-{1'b0, lo[0]})
                                   : hnq_pkg::NRM_W'({1'b0, lo[0]});
      ny = sy_r[hnq_pkg::ACC_W-1] ? hnq_pkg::NRM_W'(-{1'b0, lo[1]})
                                   : hnq_pkg::NRM_W'({1'b0, lo[1]});
      nz = hnq_pkg::NRM_W'({1'b0, lo[2]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heightmap normal query unit. Writes and queries
// go in through the input stream, and the map size is set over APB between
// phases. An in-bench height map predicts every query result. That result is
// compared field by field with what comes out of the output stream.
// ----------------------------------------------------------------------------
module tb;

  localparam int  QONE        = 16384;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  SETTLE      = 100;
  localparam logic [2:0] ADDR_MAP_SIZE = 3'd0;
  localparam logic [2:0] ADDR_UNUSED   = 3'd4;

  typedef struct packed {
    logic [7:0]         height;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } query_result_t;

  class normal_scoreboard;
    logic [7:0]     heights[hnq_pkg::MAX_SIDE*hnq_pkg::MAX_SIDE];
    bit             written[hnq_pkg::MAX_SIDE*hnq_pkg::MAX_SIDE];
    int unsigned    size_reg;
    query_result_t  expected_results[$];
    int             errors;

    function new();
      size_reg = hnq_pkg::MAX_SIDE;
      errors   = 0;
    endfunction

    function int side();
      if (size_reg < hnq_pkg::MIN_SIDE) return hnq_pkg::MIN_SIDE;
      if (size_reg > hnq_pkg::MAX_SIDE) return hnq_pkg::MAX_SIDE;
      return size_reg;
    endfunction

    function int clamp(int p);
      if (p < 0) return 0;
      if (p > side() - 1) return side() - 1;
      return p;
    endfunction

    function bit is_interior(int x, int y);
      return x >= 1 && y >= 1 && x + 2 < side() && y + 2 < side();
    endfunction

    function int h(int i, int j);
      return heights[i + j * side()];
    endfunction

    // round(QONE*s/sqrt(q)), ties away from zero, by exact integer search
    function int unit_component(int s, longint unsigned q);
      longint unsigned mag, rhs, d;
      int unsigned lo, hi, mid;
      mag = (s < 0) ? -s : s;
      rhs = (mag * mag) << 30;
      lo = 0;
      hi = QONE;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        d = 2 * longint'(mid) - 1;
        if (d * d * q <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return (s < 0) ? -int'(lo) : int'(lo);
    endfunction

    function void note_input(hnq_pkg::cmd_t cmd, int px, int py, int smp);
      int x, y, sx, sy;
      longint unsigned q;
      query_result_t r;
      if (cmd == hnq_pkg::CMD_WRITE) begin
        if (px >= 0 && py >= 0 && px < side() && py < side()) begin
          heights[px + py * side()] = smp[7:0];
          written[px + py * side()] = 1'b1;
        end
        return;
      end
      x = clamp(px);
      y = clamp(py);
      r = '0;
      r.height = 8'(h(x, y));
      if (is_interior(x, y)) begin
        // six faces over the 3x3 window, z term is 6 faces * 4
        sx = (h(x,y) - h(x+1,y)) + (h(x+1,y) - h(x+2,y))
           + (h(x+1,y+1) - h(x+2,y+1))
           + (h(x,y+1) - h(x+1,y+1)) + (h(x,y+2) - h(x+1,y+2))
           + (h(x+1,y+2) - h(x+2,y+2));
        sy = (h(x,y) - h(x,y+1)) + (h(x+1,y) - h(x+1,y+1))
           + (h(x+1,y+1) - h(x+1,y+2))
           + (h(x+1,y) - h(x+1,y+1)) + (h(x+1,y+1) - h(x+1,y+2))
           + (h(x+2,y+1) - h(x+2,y+2));
        q = longint'(sx) * sx + longint'(sy) * sy + 576;
        r.nx = 16'(unit_component(sx, q));
        r.ny = 16'(unit_component(sy, q));
        r.nz = 16'(unit_component(24, q));
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [55:0] data);
      query_result_t e;
      if (expected_results.size() == 0) begin
        $error("result transfer with no query outstanding: %h", data);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (data[7:0] !== e.height) begin
        $error("height_quarters: expected %0d, got %0d", e.height, data[7:0]);
        errors++;
      end
      if (data[23:8] !== e.nx) begin
        $error("normal_x: expected %0d, got %0d", e.nx, $signed(data[23:8]));
        errors++;
      end
      if (data[39:24] !== e.ny) begin
        $error("normal_y: expected %0d, got %0d", e.ny, $signed(data[39:24]));
        errors++;
      end
      if (data[55:40] !== e.nz) begin
        $error("normal_z: expected %0d, got %0d", e.nz, $signed(data[55:40]));
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  normal_scoreboard sb = new();
  bit          no_idle = 1'b0;
  int          stall_left = 0;
  int          cycles = 0;

  always #6 clk = ~clk;

  heightmap_normal_query_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver stalls in bursts unless no_idle is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(15) == 0) begin
      stall_left = $urandom_range(19, 1) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(hnq_pkg::cmd_t cmd, int px, int py, int smp);
    int gap;
    if (!no_idle && $urandom_range(7) == 0) begin
      gap = $urandom_range(19, 1);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {smp[7:0], py[15:0], px[15:0]};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, $signed(px[15:0]), $signed(py[15:0]), smp);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // write every sample a query at (px,py) will read that has no value yet
  task automatic query_at(int px, int py);
    int x, y, span;
    x = sb.clamp(px);
    y = sb.clamp(py);
    span = sb.is_interior(x, y) ? 3 : 1;
    for (int j = 0; j < span; j++)
      for (int i = 0; i < span; i++)
        if (!sb.written[(x + i) + (y + j) * sb.side()])
          send_item(hnq_pkg::CMD_WRITE, x + i, y + j, rand_sample());
    send_item(hnq_pkg::CMD_QUERY, px, py, $urandom_range(255));
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr  = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    if (addr == ADDR_MAP_SIZE) sb.size_reg = data[8:0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int n, kind;
    n = sb.side();
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(99);
      if (kind < 30)
        send_item(hnq_pkg::CMD_WRITE, $urandom_range(n - 1), $urandom_range(n - 1),
                  rand_sample());
      else if (kind < 38)
        send_item(hnq_pkg::CMD_WRITE, $urandom, $urandom, $urandom_range(255));
      else if (kind < 70)
        query_at($urandom_range(n - 3, 1), $urandom_range(n - 3, 1));
      else if (kind < 80)
        query_at($urandom_range(1) ? 0 : n - 2 + $urandom_range(1),
                 $urandom_range(n - 1));
      else if (kind < 90)
        query_at($urandom_range(n - 1), $urandom_range(1) ? 0 : n - 1);
      else
        query_at($signed(16'($urandom)), $signed(16'($urandom)));
    end
  endtask

  initial begin
    int sizes[] = '{256, 4, 511, 0, 37, 300, 5, 131, 4, 256};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    apb_write(ADDR_UNUSED, $urandom);
    apb_write(ADDR_MAP_SIZE, 32'd8);

    // directed: extremes, outside writes, clamped corners, border, steep window
    send_item(hnq_pkg::CMD_WRITE, -32768, 0, 255);
    send_item(hnq_pkg::CMD_WRITE, 3, 32767, 0);
    send_item(hnq_pkg::CMD_WRITE, 8, 8, 17);
    for (int j = 1; j <= 3; j++)
      for (int i = 1; i <= 3; i++)
        send_item(hnq_pkg::CMD_WRITE, i, j, ((i + j) % 2) ? 255 : 0);
    query_at(1, 1);
    query_at(-32768, -32768);
    query_at(32767, 32767);
    query_at(0, 3);
    query_at(3, 0);
    query_at(6, 3);
    query_at(5, 5);
    query_at(2, -1);
    wait_drained();

    foreach (sizes[p]) begin
      apb_write(ADDR_MAP_SIZE, {23'($urandom_range(8388607)), sizes[p][8:0]});
      if (p == sizes.size() - 1) begin
        no_idle = 1'b1;
      end
      random_phase(70);
      wait_drained();
    end
    apb_write(ADDR_UNUSED, $urandom);

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/hnq_pkg.sv
src/hnq_front.sv
src/hnq_fifo.sv
src/hnq_norm.sv
src/hnq_back.sv
src/heightmap_normal_query_unit.sv
tb/sv/tb.sv
